// File: rtl/core/clipped_pixel_neighbour_restore_assert.svh
// Assertion macros for the clipped pixel restore block
`ifndef CLIPPED_PIXEL_NEIGHBOUR_RESTORE_ASSERT_SVH
`define CLIPPED_PIXEL_NEIGHBOUR_RESTORE_ASSERT_SVH

// same-cycle implication
`define CPNR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPNR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cpnr_pkg.sv
package cpnr_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int RADIUS_DEF    = 2;

    localparam int RAW_W  = 16;
    localparam int COL_W  = 24;
    localparam int WT_W   = 17;
    localparam int SUM_W  = 48;
    localparam int DEN_W  = 22;
    localparam int QUO_W  = SUM_W + 2;
    localparam int SUP_W  = 6;
    localparam int MINS_W = 5;
    localparam int FW_W   = 12;
    localparam int FH_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SUPPORT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        ROLE_PRESERVED  = 2'd0,
        ROLE_RESTORED   = 2'd1,
        ROLE_UNRESOLVED = 2'd2
    } role_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CEN_RD,
        S_CEN_CHK,
        S_NB_RD,
        S_NB_MUL,
        S_NB_ACC,
        S_NB_STEP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        [RAW_W-1:0] raw;
        logic signed [COL_W-1:0] red;
        logic signed [COL_W-1:0] green;
        logic signed [COL_W-1:0] blue;
    } mem_word_t;

    function automatic logic [WT_W-1:0] weight(input logic [4:0] d2);
        logic [WT_W-1:0] w;
        case (d2)
            5'd1:    w = 17'd65536;
            5'd2:    w = 17'd46341;
            5'd3:    w = 17'd37837;
            5'd4:    w = 17'd32768;
            5'd5:    w = 17'd29309;
            5'd6:    w = 17'd26755;
            5'd7:    w = 17'd24770;
            5'd8:    w = 17'd23170;
            5'd9:    w = 17'd21845;
            5'd10:   w = 17'd20724;
            5'd13:   w = 17'd18176;
            5'd18:   w = 17'd15447;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/cpnr_if.sv
interface cpnr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [cpnr_pkg::RAW_W-1:0]    raw_sample;
    logic signed [cpnr_pkg::COL_W-1:0]    red_in;
    logic signed [cpnr_pkg::COL_W-1:0]    green_in;
    logic signed [cpnr_pkg::COL_W-1:0]    blue_in;
    logic                                 pad;

    modport source (output valid, raw_sample, red_in, green_in, blue_in, pad, input ready);
    modport sink (input valid, raw_sample, red_in, green_in, blue_in, pad, output ready);
endinterface

interface cpnr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cpnr_pkg::COL_W-1:0]    red_out;
    logic signed [cpnr_pkg::COL_W-1:0]    green_out;
    logic signed [cpnr_pkg::COL_W-1:0]    blue_out;
    logic        [1:0]                    role;
    logic                                 frame_last;

    modport source (output valid, red_out, green_out, blue_out, role, frame_last, input ready);
    modport sink (input valid, red_out, green_out, blue_out, role, frame_last, output ready);
endinterface

// File: rtl/core/cpnr_div.sv
module cpnr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [cpnr_pkg::SUM_W-1:0]   num,
    input  logic        [cpnr_pkg::DEN_W-1:0]   den,
    output logic                                busy,
    output logic signed [cpnr_pkg::COL_W-1:0]   quo
);

    localparam int QW = cpnr_pkg::QUO_W;
    localparam int DW = cpnr_pkg::DEN_W;
    localparam int CW = $clog2(QW + 1);

    logic                busy_reg, busy_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [QW-1:0]       dvd_reg, dvd_next;
    logic [DW:0]         dvs_reg, dvs_next;
    logic [DW:0]         rem_reg, rem_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic                neg_reg, neg_next;

    logic [cpnr_pkg::SUM_W-1:0] mag;
    logic [DW+1:0]              trial;
    logic [cpnr_pkg::COL_W-1:0] qlow;

    always_comb
    begin
        mag       = num[cpnr_pkg::SUM_W-1] ? cpnr_pkg::SUM_W'(-num) : cpnr_pkg::SUM_W'(num);
        trial     = {rem_reg, dvd_reg[QW-1]};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            neg_next  = num[cpnr_pkg::SUM_W-1];
            dvd_next  = QW'({mag, 1'b0}) + QW'(den);
            dvs_next  = {den, 1'b0};
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = (DW+1)'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign qlow = quo_reg[cpnr_pkg::COL_W-1:0];
    assign quo  = neg_reg ? $signed(-qlow) : $signed(qlow);
    assign busy = busy_reg;

endmodule

// File: rtl/core/clipped_pixel_neighbour_restore.sv
// A preserved pixel's word passes S_CEN_RD, S_CEN_CHK and S_OUT into the output register after
// the item that brings it to the window center; a censored pixel (min support nonzero) adds
// S_NB_RD, S_NB_STEP per skipped and all four S_NB states per used window position, then three
// color divisions if restorable. Throughput: one item at a time; no other item is accepted until
// its result is queued. Output lags the input stream by RADIUS*W+RADIUS items, which pad items flush.
// Reset clears control, counters and config to defaults; datapath and line memory are not cleared.
`include "clipped_pixel_neighbour_restore_assert.svh"

module clipped_pixel_neighbour_restore #(
    parameter int MAX_WIDTH = cpnr_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS    = cpnr_pkg::RADIUS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cpnr_in_if.sink                              pix_in,
    cpnr_out_if.source                           pix_out,
    input  logic                                 cfg_we,
    input  logic [cpnr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpnr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int HIST   = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int AW     = $clog2(HIST);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = cpnr_pkg::FH_W;
    localparam int PW     = WW + HW + 1;
    localparam int DW     = $clog2(RADIUS + 1) + 1;
    localparam int OW     = AW + 2;
    localparam int SUM_W  = cpnr_pkg::SUM_W;
    localparam int DEN_W  = cpnr_pkg::DEN_W;
    localparam int COL_W  = cpnr_pkg::COL_W;
    localparam int SUP_W  = cpnr_pkg::SUP_W;
    localparam int WT_W   = cpnr_pkg::WT_W;
    localparam logic signed [OW-1:0] HIST_S = OW'(HIST);

    // config
    logic [cpnr_pkg::RAW_W-1:0]  white_reg;
    logic [cpnr_pkg::MINS_W-1:0] minsup_reg;
    logic [cpnr_pkg::FW_W-1:0]   fw_reg;
    logic [HW-1:0]               fh_reg;

    cpnr_pkg::state_t state_reg, state_next;

    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [WW-1:0]   qc_reg, qc_next;
    logic [HW-1:0]   qr_reg, qr_next;
    logic [WW-1:0]   cen_col_reg, cen_col_next;
    logic [HW-1:0]   cen_row_reg, cen_row_next;
    logic            last_reg, last_next;
    logic [AW-1:0]   c_addr_reg, c_addr_next;

    logic signed [DW-1:0] dy_reg, dy_next, dx_reg, dx_next, ring_reg, ring_next;
    logic [WT_W-1:0]      wt_reg, wt_next;
    logic                 ok_reg, ok_next;
    logic signed [SUM_W-1:0] pr_reg, pr_next, pg_reg, pg_next, pb_reg, pb_next;
    logic signed [SUM_W-1:0] sr_reg, sr_next, sg_reg, sg_next, sb_reg, sb_next;
    logic [DEN_W-1:0]     sw_reg, sw_next;
    logic [SUP_W-1:0]     sup_reg, sup_next;
    logic [1:0]           ch_reg, ch_next;

    logic signed [COL_W-1:0] rr_reg, rr_next, rg_reg, rg_next, rb_reg, rb_next;
    cpnr_pkg::role_t         role_reg, role_next;

    logic                    ov_reg, ov_next;
    logic signed [COL_W-1:0] or_reg, or_next, og_reg, og_next, ob_reg, ob_next;
    cpnr_pkg::role_t         orole_reg, orole_next;
    logic                    olast_reg, olast_next;

    // memory
    cpnr_pkg::mem_word_t mem [HIST];
    cpnr_pkg::mem_word_t rd_data_reg;
    cpnr_pkg::mem_word_t wword;
    logic [AW-1:0]       rd_addr;

    // geometry
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [PW-1:0] total, lag;

    logic acc, take, produce, out_free;

    logic signed [AW:0]   cdiff;
    logic [DW-1:0]        ady, adx, amax;
    logic [4:0]           d2;
    logic signed [HW+1:0] ny;
    logic signed [WW+1:0] nx;
    logic signed [OW-1:0] off, nsum;
    logic [AW-1:0]        naddr;
    logic                 on_ring, in_frame, use_nb;
    logic                 ring_end, dx_end, more_ring, can_restore, censored;

    logic                    div_start, div_busy;
    logic signed [SUM_W-1:0] div_num;
    logic signed [COL_W-1:0] div_quo;

    cpnr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sw_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(fw_reg);
        end
        h_eff = (fh_reg == '0) ? HW'(1) : fh_reg;
        total = PW'(w_eff) * PW'(h_eff);
        lag   = PW'(RADIUS) * PW'(w_eff) + PW'(RADIUS);
    end

    assign acc      = pix_in.valid && pix_in.ready;
    assign take     = acc && !(pix_in.pad && (p_reg < total));
    assign produce  = take && (p_reg >= lag);
    assign out_free = !ov_reg || pix_out.ready;
    assign pix_in.ready = (state_reg == cpnr_pkg::S_IDLE);

    // neighbor geometry
    always_comb
    begin
        cdiff    = $signed({1'b0, wr_ptr_reg}) - $signed({1'b0, AW'(lag)});
        ady      = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        adx      = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        amax     = (ady > adx) ? ady : adx;
        on_ring  = (amax == DW'(ring_reg));
        d2       = 5'(5'(ady) * 5'(ady)) + 5'(5'(adx) * 5'(adx));
        ny       = $signed({2'b00, cen_row_reg}) + (HW+2)'(dy_reg);
        nx       = $signed({2'b00, cen_col_reg}) + (WW+2)'(dx_reg);
        in_frame = (ny >= 0) && (ny < $signed({2'b00, h_eff}))
                && (nx >= 0) && (nx < $signed({2'b00, w_eff}));
        use_nb   = on_ring && in_frame;
        off      = OW'(dy_reg) * OW'($signed({1'b0, w_eff})) + OW'(dx_reg);
        nsum     = $signed({2'b00, c_addr_reg}) + off;
        if (nsum < 0)
        begin
            naddr = AW'(nsum + HIST_S);
        end
        else if (nsum >= HIST_S)
        begin
            naddr = AW'(nsum - HIST_S);
        end
        else
        begin
            naddr = AW'(nsum);
        end
        dx_end      = (dx_reg == ring_reg);
        ring_end    = dx_end && (dy_reg == ring_reg);
        more_ring   = (ring_reg < DW'(RADIUS)) && (sup_reg < SUP_W'(minsup_reg));
        can_restore = (sup_reg >= SUP_W'(minsup_reg)) && (sup_reg != '0);
        censored    = (rd_data_reg.raw >= white_reg);
    end

    always_comb
    begin
        case (state_reg)
            cpnr_pkg::S_NB_RD: rd_addr = naddr;
            default:           rd_addr = c_addr_reg;
        endcase
        wword.raw   = pix_in.raw_sample;
        wword.red   = pix_in.red_in;
        wword.green = pix_in.green_in;
        wword.blue  = pix_in.blue_in;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mem[wr_ptr_reg] <= wword;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpnr_pkg::S_IDLE:
            begin
                if (produce)
                begin
                    state_next = cpnr_pkg::S_CEN_RD;
                end
            end
            cpnr_pkg::S_CEN_RD:
            begin
                state_next = cpnr_pkg::S_CEN_CHK;
            end
            cpnr_pkg::S_CEN_CHK:
            begin
                if (censored && (minsup_reg != '0))
                begin
                    state_next = cpnr_pkg::S_NB_RD;
                end
                else
                begin
                    state_next = cpnr_pkg::S_OUT;
                end
            end
            cpnr_pkg::S_NB_RD:
            begin
                state_next = use_nb ? cpnr_pkg::S_NB_MUL : cpnr_pkg::S_NB_STEP;
            end
            cpnr_pkg::S_NB_MUL:
            begin
                state_next = cpnr_pkg::S_NB_ACC;
            end
            cpnr_pkg::S_NB_ACC:
            begin
                state_next = cpnr_pkg::S_NB_STEP;
            end
            cpnr_pkg::S_NB_STEP:
            begin
                if (!ring_end || more_ring)
                begin
                    state_next = cpnr_pkg::S_NB_RD;
                end
                else if (can_restore)
                begin
                    state_next = cpnr_pkg::S_DIV_GO;
                end
                else
                begin
                    state_next = cpnr_pkg::S_OUT;
                end
            end
            cpnr_pkg::S_DIV_GO:
            begin
                state_next = cpnr_pkg::S_DIV_WAIT;
            end
            cpnr_pkg::S_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = (ch_reg == 2'd2) ? cpnr_pkg::S_OUT : cpnr_pkg::S_DIV_GO;
                end
            end
            cpnr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = cpnr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cpnr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        p_next       = p_reg;
        qc_next      = qc_reg;
        qr_next      = qr_reg;
        cen_col_next = cen_col_reg;
        cen_row_next = cen_row_reg;
        last_next    = last_reg;
        c_addr_next  = c_addr_reg;
        dy_next      = dy_reg;
        dx_next      = dx_reg;
        ring_next    = ring_reg;
        wt_next      = wt_reg;
        ok_next      = ok_reg;
        pr_next      = pr_reg;
        pg_next      = pg_reg;
        pb_next      = pb_reg;
        sr_next      = sr_reg;
        sg_next      = sg_reg;
        sb_next      = sb_reg;
        sw_next      = sw_reg;
        sup_next     = sup_reg;
        ch_next      = ch_reg;
        rr_next      = rr_reg;
        rg_next      = rg_reg;
        rb_next      = rb_reg;
        role_next    = role_reg;
        ov_next      = ov_reg && !pix_out.ready;
        or_next      = or_reg;
        og_next      = og_reg;
        ob_next      = ob_reg;
        orole_next   = orole_reg;
        olast_next   = olast_reg;
        div_start    = 1'b0;
        case (ch_reg)
            2'd0:    div_num = sr_reg;
            2'd1:    div_num = sg_reg;
            default: div_num = sb_reg;
        endcase

        if (take)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(HIST - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (produce)
            begin
                cen_col_next = qc_reg;
                cen_row_next = qr_reg;
                last_next    = (qc_reg == w_eff - 1'b1) && (qr_reg == h_eff - 1'b1);
                c_addr_next  = cdiff[AW] ? AW'(cdiff + (AW+1)'(HIST)) : AW'(cdiff);
                if (qc_reg + 1'b1 >= w_eff)
                begin
                    qc_next = '0;
                    qr_next = qr_reg + 1'b1;
                end
                else
                begin
                    qc_next = qc_reg + 1'b1;
                end
            end
            if (p_reg + 1'b1 >= total + lag)
            begin
                p_next  = '0;
                qc_next = '0;
                qr_next = '0;
            end
            else
            begin
                p_next = p_reg + 1'b1;
            end
        end

        if (cfg_we && ((cfg_index == cpnr_pkg::REG_FRAME_WIDTH)
                    || (cfg_index == cpnr_pkg::REG_FRAME_HEIGHT)))
        begin
            p_next  = '0;
            qc_next = '0;
            qr_next = '0;
        end

        case (state_reg)
            cpnr_pkg::S_CEN_CHK:
            begin
                rr_next   = rd_data_reg.red;
                rg_next   = rd_data_reg.green;
                rb_next   = rd_data_reg.blue;
                role_next = censored ? cpnr_pkg::ROLE_UNRESOLVED : cpnr_pkg::ROLE_PRESERVED;
                sr_next   = '0;
                sg_next   = '0;
                sb_next   = '0;
                sw_next   = '0;
                sup_next  = '0;
                ring_next = DW'(1);
                dy_next   = -DW'(1);
                dx_next   = -DW'(1);
            end
            cpnr_pkg::S_NB_RD:
            begin
                wt_next = cpnr_pkg::weight(d2);
            end
            cpnr_pkg::S_NB_MUL:
            begin
                ok_next = !censored;
                pr_next = SUM_W'($signed({1'b0, wt_reg}) * rd_data_reg.red);
                pg_next = SUM_W'($signed({1'b0, wt_reg}) * rd_data_reg.green);
                pb_next = SUM_W'($signed({1'b0, wt_reg}) * rd_data_reg.blue);
            end
            cpnr_pkg::S_NB_ACC:
            begin
                if (ok_reg)
                begin
                    sr_next  = sr_reg + pr_reg;
                    sg_next  = sg_reg + pg_reg;
                    sb_next  = sb_reg + pb_reg;
                    sw_next  = sw_reg + DEN_W'(wt_reg);
                    sup_next = sup_reg + 1'b1;
                end
            end
            cpnr_pkg::S_NB_STEP:
            begin
                if (ring_end)
                begin
                    if (more_ring)
                    begin
                        ring_next = ring_reg + 1'b1;
                        dy_next   = -(ring_reg + 1'b1);
                        dx_next   = -(ring_reg + 1'b1);
                    end
                    ch_next = 2'd0;
                end
                else if (dx_end)
                begin
                    dx_next = -ring_reg;
                    dy_next = dy_reg + 1'b1;
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            cpnr_pkg::S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            cpnr_pkg::S_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    case (ch_reg)
                        2'd0:    rr_next = div_quo;
                        2'd1:    rg_next = div_quo;
                        default: rb_next = div_quo;
                    endcase
                    ch_next   = ch_reg + 1'b1;
                    role_next = cpnr_pkg::ROLE_RESTORED;
                end
            end
            cpnr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    or_next    = rr_reg;
                    og_next    = rg_reg;
                    ob_next    = rb_reg;
                    orole_next = role_reg;
                    olast_next = last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cpnr_pkg::S_IDLE;
            white_reg  <= 16'hFFFF;
            minsup_reg <= 5'd3;
            fw_reg     <= 12'd2048;
            fh_reg     <= 16'd1080;
            wr_ptr_reg <= '0;
            p_reg      <= '0;
            qc_reg     <= '0;
            qr_reg     <= '0;
            ov_reg     <= 1'b0;
            ch_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            p_reg      <= p_next;
            qc_reg     <= qc_next;
            qr_reg     <= qr_next;
            ov_reg     <= ov_next;
            ch_reg     <= ch_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    cpnr_pkg::REG_WHITE_LEVEL:  white_reg  <= cfg_data;
                    cpnr_pkg::REG_MIN_SUPPORT:  minsup_reg <= cfg_data[cpnr_pkg::MINS_W-1:0];
                    cpnr_pkg::REG_FRAME_WIDTH:  fw_reg     <= cfg_data[cpnr_pkg::FW_W-1:0];
                    cpnr_pkg::REG_FRAME_HEIGHT: fh_reg     <= cfg_data;
                    default:                    fh_reg     <= fh_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cen_col_reg <= cen_col_next;
        cen_row_reg <= cen_row_next;
        last_reg    <= last_next;
        c_addr_reg  <= c_addr_next;
        dy_reg      <= dy_next;
        dx_reg      <= dx_next;
        ring_reg    <= ring_next;
        wt_reg      <= wt_next;
        ok_reg      <= ok_next;
        pr_reg      <= pr_next;
        pg_reg      <= pg_next;
        pb_reg      <= pb_next;
        sr_reg      <= sr_next;
        sg_reg      <= sg_next;
        sb_reg      <= sb_next;
        sw_reg      <= sw_next;
        sup_reg     <= sup_next;
        rr_reg      <= rr_next;
        rg_reg      <= rg_next;
        rb_reg      <= rb_next;
        role_reg    <= role_next;
        or_reg      <= or_next;
        og_reg      <= og_next;
        ob_reg      <= ob_next;
        orole_reg   <= orole_next;
        olast_reg   <= olast_next;
    end

    assign pix_out.valid      = ov_reg;
    assign pix_out.red_out    = or_reg;
    assign pix_out.green_out  = og_reg;
    assign pix_out.blue_out   = ob_reg;
    assign pix_out.role       = orole_reg;
    assign pix_out.frame_last = olast_reg;

    `CPNR_ASSERT_IMP(a_div_only_waiting, clk, rst_n, div_busy, state_reg == cpnr_pkg::S_DIV_WAIT, "divider busy outside wait state")
    `CPNR_ASSERT_NXT(a_center_read, clk, rst_n, produce, state_reg == cpnr_pkg::S_CEN_RD, "center read not issued")
    `CPNR_ASSERT_NXT(a_out_load, clk, rst_n, (state_reg == cpnr_pkg::S_OUT) && out_free, pix_out.valid && (state_reg == cpnr_pkg::S_IDLE), "result word not loaded")

endmodule
